// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file bale_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bale_pkg.sv =====
// ----------------------------------------------------------------------------
// bale_pkg
// types, codes and helpers of the bounded array list engine
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int CAPW       = 7;
	localparam int IDXW       = 6;
	localparam int CNTW       = 7;
	localparam int FIELDW     = 32;
	localparam int CMPW       = (CW > CAPW) ? CW : CAPW;

	localparam logic [CAPW-1:0] CAP_RESET = 7'd64;

	// operation codes
	localparam logic [3:0] FN_INS_HEAD = 4'd0;
	localparam logic [3:0] FN_INS_TAIL = 4'd1;
	localparam logic [3:0] FN_INS_AT   = 4'd2;
	localparam logic [3:0] FN_INS_SORT = 4'd3;
	localparam logic [3:0] FN_RM_HEAD  = 4'd4;
	localparam logic [3:0] FN_RM_TAIL  = 4'd5;
	localparam logic [3:0] FN_RM_AT    = 4'd6;
	localparam logic [3:0] FN_RM_VAL   = 4'd7;
	localparam logic [3:0] FN_SEARCH   = 4'd8;
	localparam logic [3:0] FN_COUNT    = 4'd9;

	// status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_RANGE = 2'd3;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [3:0]               func;
		logic signed [FIELDW-1:0] value_in;
		logic [IDXW-1:0]          position;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [IDXW-1:0]          index_out;
		logic signed [FIELDW-1:0] value_out;
		logic [CNTW-1:0]          count_out;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_GET_RD,
		S_GET_WAIT,
		S_OPEN_RD,
		S_OPEN_WR,
		S_PUT,
		S_CLOSE_RD,
		S_CLOSE_WR,
		S_FINISH,
		S_DONE
	} state_t;

	// field to stored word: sign extend or cut
	function automatic word_t to_word(logic [FIELDW-1:0] v);
		logic [FIELDW+63:0] ext;
		ext = {{64{v[FIELDW-1]}}, v};
		return ext[DATA_WIDTH-1:0];
	endfunction

	// stored word to field: sign extend then cut
	function automatic logic [FIELDW-1:0] to_field(word_t w);
		logic [DATA_WIDTH+63:0] ext;
		ext = {{64{w[DATA_WIDTH-1]}}, w};
		return ext[FIELDW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bounded_array_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_engine_core
// bounded ordered list of signed words held in a single-port-write memory
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_stall / req) carries one operation request:
//   insert head, tail, at index or sorted; remove head, tail, at index or by
//   value; search; count. taken when req_valid is high and req_stall is low.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   request: status, index, value and the count after the operation.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the capacity; write
//   it only while no request is in flight.
// operation:
//   one request at a time. a count or a failed request goes from decode
//   straight to its result. a sorted insert, a search and a remove by value
//   first scan the entries in order, comparing each; a remove by head, tail
//   or index first reads its entry. an insert then shifts entries up to open
//   a gap and writes the value; a remove shifts entries down to close it.
//   all entry reads go through the one registered read port
// reset and stall:
//   arst_n clears the count, the state machine and the result flag, holds
//   req_stall high and cfg_ready low, and returns the capacity to 64. the
//   entry memory has no reset: only entries below the count are ever used.
//   a stalled result holds in the output register; the next request is still
//   taken and worked, then waits in its final state until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  bale_pkg::req_t            req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output bale_pkg::rsp_t            rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bale_pkg::CAPW-1:0] cfg_data
);
	import bale_pkg::*;

	// entry store, registered read
	word_t mem [DEPTH];
	word_t rd_q;

	state_t state_q, state_d;

	logic [CAPW-1:0] capacity_q;
	logic [CW-1:0]   count_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	// operation context
	logic [3:0]      func_q;
	word_t           val_q;
	logic [IDXW-1:0] pos_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   ptr_q;
	word_t           word_q;
	logic [1:0]      status_q;

	// memory port controls
	logic [AW-1:0] raddr;
	logic          mem_we;
	logic [AW-1:0] waddr;
	word_t         wdata;

	// decode helpers
	logic [CMPW-1:0] cap_ext;
	logic [CMPW-1:0] depth_ext;
	logic [CMPW-1:0] cap_lim;
	logic [CMPW-1:0] count_ext;
	logic [CMPW-1:0] pos_ext;
	logic            full;
	logic            empty;
	logic            pos_gt_count;
	logic            pos_lt_count;
	logic [CW-1:0]   count_m1;
	logic [CW-1:0]   ptr_dec;
	logic [CW:0]     ptr_inc;
	logic            is_sort;
	logic            is_rmval;
	logic            hit;
	logic            scan_end;
	logic            open_end;
	logic            close_end;
	logic            out_free;

	// capacity above the store depth acts as the depth
	assign cap_ext      = CMPW'(capacity_q);
	assign depth_ext    = CMPW'(DEPTH);
	assign cap_lim      = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign count_ext    = CMPW'(count_q);
	assign pos_ext      = CMPW'(pos_q);
	assign full         = count_ext >= cap_lim;
	assign empty        = count_q == '0;
	assign pos_gt_count = pos_ext > count_ext;
	assign pos_lt_count = pos_ext < count_ext;
	assign count_m1     = count_q - 1'b1;
	assign ptr_dec      = ptr_q - 1'b1;
	assign ptr_inc      = {1'b0, ptr_q} + 1'b1;

	assign is_sort  = func_q == FN_INS_SORT;
	assign is_rmval = func_q == FN_RM_VAL;

	// sorted insert stops at the first entry greater than the value
	assign hit = is_sort ? ($signed(rd_q) > $signed(val_q)) : (rd_q == val_q);

	assign scan_end  = ptr_q == count_q;
	assign open_end  = ptr_q == idx_q;
	assign close_end = ptr_inc >= {1'b0, count_q};
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (func_q)
					FN_INS_HEAD, FN_INS_TAIL: state_d = full ? S_DONE : S_OPEN_RD;
					FN_INS_AT: state_d = (full || pos_gt_count) ? S_DONE : S_OPEN_RD;
					FN_INS_SORT: state_d = full ? S_DONE : S_SCAN_RD;
					FN_RM_HEAD, FN_RM_TAIL: state_d = empty ? S_DONE : S_GET_RD;
					FN_RM_AT: state_d = (empty || !pos_lt_count) ? S_DONE : S_GET_RD;
					FN_RM_VAL: state_d = empty ? S_DONE : S_SCAN_RD;
					FN_SEARCH: state_d = S_SCAN_RD;
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN_RD: begin
				if (scan_end) state_d = is_sort ? S_OPEN_RD : S_DONE;
				else state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (hit) begin
					if (is_sort) state_d = S_OPEN_RD;
					else if (is_rmval) state_d = S_CLOSE_RD;
					else state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_GET_RD:   state_d = S_GET_WAIT;
			S_GET_WAIT: state_d = S_CLOSE_RD;
			S_OPEN_RD:  state_d = open_end ? S_PUT : S_OPEN_WR;
			S_OPEN_WR:  state_d = S_OPEN_RD;
			S_PUT:      state_d = S_DONE;
			S_CLOSE_RD: state_d = close_end ? S_FINISH : S_CLOSE_WR;
			S_CLOSE_WR: state_d = S_CLOSE_RD;
			S_FINISH:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		// no request is taken while reset is held
		req_stall = !arst_n || (state_q != S_IDLE);
		raddr     = '0;
		mem_we    = 1'b0;
		waddr     = '0;
		wdata     = rd_q;
		case (state_q)
			S_SCAN_RD:  raddr = ptr_q[AW-1:0];
			S_GET_RD:   raddr = idx_q[AW-1:0];
			S_OPEN_RD:  raddr = ptr_dec[AW-1:0];
			S_OPEN_WR: begin
				mem_we = 1'b1;
				waddr  = ptr_q[AW-1:0];
			end
			S_PUT: begin
				mem_we = 1'b1;
				waddr  = idx_q[AW-1:0];
				wdata  = val_q;
			end
			S_CLOSE_RD: raddr = ptr_inc[AW-1:0];
			S_CLOSE_WR: begin
				mem_we = 1'b1;
				waddr  = ptr_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// entry store
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) capacity_q <= cfg_data;
			if (state_q == S_PUT) count_q <= count_q + 1'b1;
			else if (state_q == S_FINISH) count_q <= count_m1;
			if (state_q == S_DONE && out_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// operation context and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					func_q <= req.func;
					val_q  <= to_word(req.value_in);
					pos_q  <= req.position;
				end
			end
			S_DECODE: begin
				// failures and count report index and value zero
				status_q <= STS_DONE;
				idx_q    <= '0;
				word_q   <= '0;
				ptr_q    <= '0;
				case (func_q)
					FN_INS_HEAD: begin
						if (full) status_q <= STS_FULL;
						else ptr_q <= count_q;
					end
					FN_INS_TAIL: begin
						if (full) status_q <= STS_FULL;
						else begin
							idx_q <= count_q;
							ptr_q <= count_q;
						end
					end
					FN_INS_AT: begin
						// full check comes before the index check
						if (full) status_q <= STS_FULL;
						else if (pos_gt_count) status_q <= STS_RANGE;
						else begin
							idx_q <= CW'(pos_q);
							ptr_q <= count_q;
						end
					end
					FN_INS_SORT: begin
						if (full) status_q <= STS_FULL;
					end
					FN_RM_HEAD: begin
						if (empty) status_q <= STS_EMPTY;
					end
					FN_RM_TAIL: begin
						if (empty) status_q <= STS_EMPTY;
						else idx_q <= count_m1;
					end
					FN_RM_AT: begin
						if (empty) status_q <= STS_EMPTY;
						else if (pos_lt_count) idx_q <= CW'(pos_q);
						else status_q <= STS_RANGE;
					end
					FN_RM_VAL: begin
						if (empty) status_q <= STS_EMPTY;
					end
					default: ;
				endcase
			end
			S_SCAN_RD: begin
				if (scan_end) begin
					// no greater entry: sorted insert appends
					if (is_sort) begin
						idx_q <= count_q;
						ptr_q <= count_q;
					end else begin
						status_q <= STS_EMPTY;
					end
				end
			end
			S_SCAN_CMP: begin
				if (hit) begin
					idx_q <= ptr_q;
					if (is_sort) ptr_q <= count_q;
					else word_q <= rd_q;
				end else begin
					ptr_q <= ptr_inc[CW-1:0];
				end
			end
			S_GET_WAIT: begin
				word_q <= rd_q;
				ptr_q  <= idx_q;
			end
			S_OPEN_WR:  ptr_q <= ptr_dec;
			S_CLOSE_WR: ptr_q <= ptr_inc[CW-1:0];
			S_DONE: begin
				if (out_free) begin
					rsp_q.status    <= status_q;
					rsp_q.index_out <= IDXW'(idx_q);
					rsp_q.value_out <= to_field(word_q);
					rsp_q.count_out <= CNTW'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready = arst_n;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/bale_chk.sv =====
// ----------------------------------------------------------------------------
// bale_chk
// port-level checks of the list engine result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module bale_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input bale_pkg::rsp_t rsp
);
	import bale_pkg::*;

	// a stalled result holds
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

	// the count never exceeds the store depth
	`CHK_SAME(a_count_range, clk, arst_n, rsp_valid, rsp.count_out <= CNTW'(DEPTH), "count above depth")

	// a failed operation reports index and value zero
	`CHK_SAME(a_fail_zero, clk, arst_n, rsp_valid && (rsp.status != STS_DONE), (rsp.index_out == '0) && (rsp.value_out == '0), "failure with nonzero index or value")

endmodule

bind bounded_array_list_engine_core bale_chk u_bale_chk (.*);

`default_nettype wire

// ===== verif/list_result_checker.sv =====
// ----------------------------------------------------------------------------
// list_result_checker
// watches the request, result and capacity channels of the list engine,
// keeps its own copy of the list and compares every result field by field
// ----------------------------------------------------------------------------
`default_nettype none

module list_result_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  bale_pkg::req_t            req,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  bale_pkg::rsp_t            rsp,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [bale_pkg::CAPW-1:0] cfg_data,
	output int                        fail_count,
	output int                        outstanding,
	output int                        list_len,
	output int                        rsp_checked
);
	import bale_pkg::*;

	logic signed [FIELDW-1:0] slots [DEPTH];
	int                       len = 0;
	logic [CAPW-1:0]          cap = CAP_RESET;
	rsp_t                     rsp_due [$];
	int                       errors = 0;
	int                       checked = 0;

	// first slot holding v, or -1
	function automatic int find_first(logic signed [FIELDW-1:0] v);
		int k;
		for (k = 0; k < len; k++)
			if (slots[k] == v)
				return k;
		return -1;
	endfunction

	// performs one request on the local list and returns its result
	function automatic rsp_t apply_list_op(req_t r);
		rsp_t                     o;
		int                       lim;
		int                       at;
		int                       k;
		logic signed [FIELDW-1:0] v;
		o = '0;
		v = r.value_in;
		lim = (cap > DEPTH) ? DEPTH : int'(cap);
		case (r.func)
			FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT, FN_INS_SORT: begin
				if (len >= lim) begin
					o.status = STS_FULL;
				end else begin
					at = len;
					if (r.func == FN_INS_HEAD) begin
						at = 0;
					end else if (r.func == FN_INS_AT) begin
						at = r.position;
					end else if (r.func == FN_INS_SORT) begin
						// before the first larger entry
						for (k = len - 1; k >= 0; k--)
							if (slots[k] > v)
								at = k;
					end
					if (at > len) begin
						o.status = STS_RANGE;
					end else begin
						for (k = len; k > at; k--)
							slots[k] = slots[k-1];
						slots[at] = v;
						len++;
						o.index_out = IDXW'(at);
					end
				end
			end
			FN_RM_HEAD, FN_RM_TAIL, FN_RM_AT, FN_RM_VAL: begin
				if (len == 0) begin
					o.status = STS_EMPTY;
				end else begin
					if (r.func == FN_RM_HEAD)
						at = 0;
					else if (r.func == FN_RM_TAIL)
						at = len - 1;
					else if (r.func == FN_RM_AT)
						at = (r.position < len) ? int'(r.position) : -2;
					else
						at = find_first(v);
					if (at == -2) begin
						o.status = STS_RANGE;
					end else if (at < 0) begin
						o.status = STS_EMPTY;
					end else begin
						o.index_out = IDXW'(at);
						o.value_out = slots[at];
						for (k = at; k + 1 < len; k++)
							slots[k] = slots[k+1];
						len--;
					end
				end
			end
			FN_SEARCH: begin
				at = find_first(v);
				if (at < 0) begin
					o.status = STS_EMPTY;
				end else begin
					o.index_out = IDXW'(at);
					o.value_out = slots[at];
				end
			end
			default: ;
		endcase
		o.count_out = CNTW'(len);
		return o;
	endfunction

	task automatic cmp_field(string fname, logic [FIELDW-1:0] want, logic [FIELDW-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			len = 0;
			cap = CAP_RESET;
			rsp_due.delete();
			fail_count  <= errors;
			outstanding <= 0;
			list_len    <= 0;
			rsp_checked <= checked;
		end else begin
			if (cfg_valid && cfg_ready)
				cap = cfg_data;
			// results first, so a spurious one never meets a request of this cycle
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: result with none pending, got %0h", $time, rsp);
				end else begin
					want = rsp_due.pop_front();
					cmp_field("status", FIELDW'(want.status), FIELDW'(rsp.status));
					cmp_field("index_out", FIELDW'(want.index_out), FIELDW'(rsp.index_out));
					cmp_field("value_out", want.value_out, rsp.value_out);
					cmp_field("count_out", FIELDW'(want.count_out), FIELDW'(rsp.count_out));
					checked++;
				end
			end
			if (req_valid && !req_stall)
				rsp_due.push_back(apply_list_op(req));
			fail_count  <= errors;
			outstanding <= rsp_due.size();
			list_len    <= len;
			rsp_checked <= checked;
		end
	end

endmodule

`default_nettype wire

// ===== verif/bounded_array_list_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_engine_core_tb
// drives list operations into the engine under several capacities, with
// random gaps and stalls on both channels, and lets the checker judge results
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine_core_tb;
	import bale_pkg::*;

	// unused operation codes behave as count; this is the top one
	localparam logic [3:0] FN_UNUSED_TOP = 4'd15;
	// longer than the worst request (full scan or full shift plus read)
	localparam int SETTLE = 300;
	localparam int LIMIT  = 1_500_000;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	req_t            req       = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	rsp_t            rsp;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [CAPW-1:0] cfg_data  = '0;

	int fail_count;
	int outstanding;
	int list_len;
	int rsp_checked;

	// shared pacing controls
	bit calm      = 1'b0;  // no idle cycles on either side
	bit long_hold = 1'b0;  // receiver holds off for a long stretch
	int cycles    = 0;
	int sent      = 0;
	int settings  = 0;

	bounded_array_list_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	list_result_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.list_len    (list_len),
		.rsp_checked (rsp_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop for a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stall before each result, or one long hold-off
	initial begin : receiver
		int n;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				// block fills up behind the held result and stalls its input
				long_hold = 1'b0;
				rsp_stall <= 1'b1;
				repeat (SETTLE) @(posedge clk);
			end else begin
				n = calm ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	function automatic req_t mk_req(logic [3:0] f, logic [FIELDW-1:0] v, int p);
		req_t r;
		r.func     = f;
		r.value_in = v;
		r.position = IDXW'(p);
		return r;
	endfunction

	// values mostly from a small pool so searches and removes find matches
	function automatic logic [FIELDW-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return $urandom_range(0, 8) - 4;
		if (roll == 6)
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0;
				default: return 32'hffff_ffff;
			endcase
		return $urandom;
	endfunction

	// random request; ins_pct steers the list toward growing or draining
	function automatic req_t rand_req(int ins_pct);
		int         roll;
		int         top;
		logic [3:0] f;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			f = 4'($urandom_range(FN_INS_HEAD, FN_INS_SORT));
		else if (roll < 90)
			f = 4'($urandom_range(FN_RM_HEAD, FN_RM_VAL));
		else if (roll < 97)
			f = FN_SEARCH;
		else
			f = 4'($urandom_range(FN_COUNT, FN_UNUSED_TOP));
		// positions mostly near the live length, sometimes anywhere
		top = (list_len + 1 > 63) ? 63 : list_len + 1;
		return mk_req(f, pick_value(),
			($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, top));
	endfunction

	// offer one request after a random gap, hold it until taken
	task automatic push_req(input req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_capacity(input logic [CAPW-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		settings++;
		repeat (2) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CAPW-1:0] c, input int n, input int ins_pct,
	                         input bit quiet, input bit hold);
		int i;
		write_capacity(c);
		calm = quiet;
		for (i = 0; i < n; i++) begin
			if (hold && i == n / 3)
				long_hold = 1'b1;
			push_req(rand_req(ins_pct));
			// occasional full drain mid-phase
			if ($urandom_range(0, 49) == 0)
				drain();
		end
		drain();
		calm = 1'b0;
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small capacity so full, empty and range cases come quickly
		write_capacity(7'd4);
		push_req(mk_req(FN_RM_HEAD, 32'h0, 0));            // removes on empty list
		push_req(mk_req(FN_RM_TAIL, 32'h0, 0));
		push_req(mk_req(FN_RM_AT, 32'h0, 0));
		push_req(mk_req(FN_RM_VAL, 32'h5, 0));
		push_req(mk_req(FN_SEARCH, 32'h0, 0));             // search on empty list
		push_req(mk_req(FN_COUNT, 32'hffff_ffff, 63));
		push_req(mk_req(FN_INS_SORT, 32'h5, 0));           // sorted insert into empty list
		push_req(mk_req(FN_INS_HEAD, 32'h8000_0000, 0));   // most negative word
		push_req(mk_req(FN_INS_TAIL, 32'h7fff_ffff, 0));   // most positive word
		push_req(mk_req(FN_INS_AT, 32'h1, 63));            // index past the count
		push_req(mk_req(FN_INS_SORT, 32'h5, 0));           // goes after the equal entry
		push_req(mk_req(FN_INS_AT, 32'h2, 3));             // list full
		push_req(mk_req(FN_INS_AT, 32'h2, 63));            // full wins over index
		push_req(mk_req(FN_RM_AT, 32'h0, 63));             // remove index out of range
		push_req(mk_req(FN_RM_VAL, 32'd12345, 0));         // value not present
		push_req(mk_req(FN_SEARCH, 32'h7fff_ffff, 0));
		push_req(mk_req(FN_RM_VAL, 32'h5, 0));             // first of two equal entries
		push_req(mk_req(FN_UNUSED_TOP, 32'h0, 0));         // unused code acts as count
		push_req(mk_req(FN_INS_AT, 32'hffff_ffff, 3));     // index equal to count appends
		push_req(mk_req(FN_RM_AT, 32'h0, 1));
		push_req(mk_req(FN_RM_TAIL, 32'h0, 0));
		push_req(mk_req(FN_RM_HEAD, 32'h0, 0));
		push_req(mk_req(FN_INS_SORT, 32'hffff_fff9, 0));   // negative sorts to the front
		push_req(mk_req(FN_SEARCH, 32'hffff_fff9, 0));
		push_req(mk_req(FN_INS_AT, 32'h0, 0));
		drain();

		// random phases: capacity, items, insert share, no idling, long hold-off
		run_phase(7'd64, 250, 65, 1'b0, 1'b1);   // grows under a capacity equal to the store depth
		run_phase(7'd5, 100, 40, 1'b0, 1'b0);    // capacity below the current count
		run_phase(7'd0, 60, 50, 1'b1, 1'b0);     // every insert reports full
		run_phase(7'd127, 250, 60, 1'b0, 1'b1);  // above store depth, reaches 64
		run_phase(7'd1, 100, 50, 1'b0, 1'b0);
		run_phase(7'd16, 250, 50, 1'b1, 1'b0);
		run_phase(7'd100, 150, 45, 1'b0, 1'b0);
		run_phase(7'd64, 100, 50, 1'b0, 1'b0);

		// let any stray result show up
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d requests and %0d checked results over %0d capacity settings",
			sent, rsp_checked, settings);
		$display("including empty, full, range and not-found cases, long hold-offs and drains");
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
